@@ hw/rtl/fsme_pkg.sv @@
// Shared types and codes for the table-driven state machine engine.
package fsme_pkg;

  localparam int StateW = 4;

  localparam logic [1:0] OpLoadEvt = 2'd0;
  localparam logic [1:0] OpLoadTmd = 2'd1;
  localparam logic [1:0] OpTrigger = 2'd2;
  localparam logic [1:0] OpRun     = 2'd3;

  localparam logic [1:0] ActEnter   = 2'd0;
  localparam logic [1:0] ActInState = 2'd1;
  localparam logic [1:0] ActExit    = 2'd2;
  localparam logic [1:0] ActTrans   = 2'd3;

  typedef struct packed {
    logic [1:0]        op;
    logic [StateW-1:0] src_state;
    logic [StateW-1:0] dst_state;
    logic [7:0]        event_code;
    logic [31:0]       interval_ms;
    logic [31:0]       now_ms;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]        action;
    logic [StateW-1:0] state_id;
    logic [3:0]        transition_index;
    logic              from_timed_table;
    logic              last;
  } res_beat_t;

  typedef struct packed {
    logic [StateW-1:0] from_st;
    logic [7:0]        key;
    logic [StateW-1:0] to_st;
  } ev_ent_t;

  typedef struct packed {
    logic [StateW-1:0] from_st;
    logic [StateW-1:0] to_st;
    logic [31:0]       interval;
  } tm_ent_t;

  typedef struct packed {
    logic [StateW-1:0] from_st;
    logic [StateW-1:0] to_st;
    logic              armed;
    logic              fire;
  } tm_rd_t;

  typedef struct packed {
    logic        we;
    logic [31:0] val;
  } tm_stw_t;

endpackage

@@ hw/rtl/fsme_evt_tbl.sv @@
// Event transition table: append-only memory with a registered read port.
module fsme_evt_tbl #(
  parameter int Depth = 16,
  localparam int IdxW = (Depth > 1) ? $clog2(Depth) : 1,
  localparam int CntW = $clog2(Depth + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load_we,
  input  fsme_pkg::ev_ent_t load_ent,
  input  logic              rd_en,
  input  logic [IdxW-1:0]   rd_idx,
  output fsme_pkg::ev_ent_t rd_ent,
  output logic [CntW-1:0]   count
);

  fsme_pkg::ev_ent_t mem [Depth];
  fsme_pkg::ev_ent_t rd_ent_r;
  logic [CntW-1:0]   count_r;
  logic              app;

  // drop loads once the table is full
  assign app = load_we && (count_r < CntW'(Depth));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (app) begin
      count_r <= count_r + CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (app) begin
      mem[count_r[IdxW-1:0]] <= load_ent;
    end
    if (rd_en) begin
      rd_ent_r <= mem[rd_idx];
    end
  end

  assign rd_ent = rd_ent_r;
  assign count  = count_r;

endmodule

@@ hw/rtl/fsme_tmr_tbl.sv @@
// Timed transition table with the shared elapsed-time subtract and compare unit.
module fsme_tmr_tbl #(
  parameter int Depth = 8,
  localparam int IdxW = (Depth > 1) ? $clog2(Depth) : 1,
  localparam int CntW = $clog2(Depth + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load_we,
  input  fsme_pkg::tm_ent_t load_ent,
  input  logic [IdxW-1:0]   addr,
  input  fsme_pkg::tm_stw_t st,
  input  logic [31:0]       now,
  output fsme_pkg::tm_rd_t  rd,
  output logic [CntW-1:0]   count
);

  logic [fsme_pkg::StateW-1:0] from_a  [Depth];
  logic [fsme_pkg::StateW-1:0] to_a    [Depth];
  logic [31:0]                 ival_a  [Depth];
  logic [31:0]                 start_a [Depth];
  logic [CntW-1:0]             count_r;
  logic [31:0]                 elapsed;
  logic                        app;

  assign app = load_we && (count_r < CntW'(Depth));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (app) begin
      count_r <= count_r + CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (app) begin
      from_a[count_r[IdxW-1:0]]  <= load_ent.from_st;
      to_a[count_r[IdxW-1:0]]    <= load_ent.to_st;
      ival_a[count_r[IdxW-1:0]]  <= load_ent.interval;
      start_a[count_r[IdxW-1:0]] <= '0;
    end else if (st.we) begin
      start_a[addr] <= st.val;
    end
  end

  // wraps modulo 2^32
  assign elapsed = now - start_a[addr];

  always_comb begin
    rd.from_st = from_a[addr];
    rd.to_st   = to_a[addr];
    rd.armed   = (start_a[addr] != '0);
    rd.fire    = (elapsed >= ival_a[addr]);
  end

  assign count = count_r;

endmodule

@@ hw/rtl/fsme_seq.sv @@
// Sequencer: table scans, action emission, timer re-arm and the last-beat hold.
module fsme_seq #(
  parameter int EvDepth = 16,
  parameter int TmDepth = 8,
  localparam int EvIdxW = (EvDepth > 1) ? $clog2(EvDepth) : 1,
  localparam int EvCntW = $clog2(EvDepth + 1),
  localparam int TmIdxW = (TmDepth > 1) ? $clog2(TmDepth) : 1,
  localparam int TmCntW = $clog2(TmDepth + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  fsme_pkg::in_beat_t          in_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [fsme_pkg::StateW-1:0] cfg_data,
  input  logic                        out_free,
  output logic                        push,
  output fsme_pkg::res_beat_t         push_beat,
  output logic                        ev_load_we,
  output fsme_pkg::ev_ent_t           ev_load_ent,
  output logic                        ev_rd_en,
  output logic [EvIdxW-1:0]           ev_rd_idx,
  input  fsme_pkg::ev_ent_t           ev_rd_ent,
  input  logic [EvCntW-1:0]           ev_count,
  output logic                        tm_load_we,
  output fsme_pkg::tm_ent_t           tm_load_ent,
  output logic [TmIdxW-1:0]           tm_addr,
  output fsme_pkg::tm_stw_t           tm_st,
  output logic [31:0]                 tm_now,
  input  fsme_pkg::tm_rd_t            tm_rd,
  input  logic [TmCntW-1:0]           tm_count
);

  typedef enum logic [3:0] {
    S_IDLE, S_RUN_ENTER, S_RUN_IN, S_EV_SCAN, S_TM_SCAN,
    S_EXIT, S_TRANS, S_ENTER, S_REARM, S_FLUSH
  } state_t;

  state_t                      state_r, state_nxt;
  logic [fsme_pkg::StateW-1:0] cur_r, cur_nxt;
  logic                        started_r, started_nxt;
  logic [7:0]                  ev_r, ev_nxt;
  logic [31:0]                 now_r, now_nxt;
  logic [EvCntW-1:0]           ev_rd_r, ev_rd_nxt;
  logic                        chk_v_r, chk_v_nxt;
  logic [EvIdxW-1:0]           chk_idx_r, chk_idx_nxt;
  logic [TmCntW-1:0]           ti_r, ti_nxt;
  logic [TmCntW-1:0]           rj_r, rj_nxt;
  logic [fsme_pkg::StateW-1:0] tk_from_r, tk_from_nxt;
  logic [fsme_pkg::StateW-1:0] tk_to_r, tk_to_nxt;
  logic [3:0]                  tk_idx_r, tk_idx_nxt;
  logic                        tk_timed_r, tk_timed_nxt;
  logic                        pend_v_r, pend_v_nxt;
  fsme_pkg::res_beat_t         pend_r, pend_nxt;
  logic                        emit, emit_ok, ev_hit;
  fsme_pkg::res_beat_t         emit_beat;

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign emit_ok   = !pend_v_r || out_free;
  assign tm_now    = now_r;
  assign ev_hit    = chk_v_r && (ev_rd_ent.from_st == cur_r) && (ev_rd_ent.key == ev_r);

  always_comb begin
    ev_load_ent = '{from_st: in_data.src_state, key: in_data.event_code,
                    to_st: in_data.dst_state};
    tm_load_ent = '{from_st: in_data.src_state, to_st: in_data.dst_state,
                    interval: in_data.interval_ms};
  end

  always_comb begin
    state_nxt    = state_r;
    cur_nxt      = cur_r;
    started_nxt  = started_r;
    ev_nxt       = ev_r;
    now_nxt      = now_r;
    ev_rd_nxt    = ev_rd_r;
    chk_v_nxt    = chk_v_r;
    chk_idx_nxt  = chk_idx_r;
    ti_nxt       = ti_r;
    rj_nxt       = rj_r;
    tk_from_nxt  = tk_from_r;
    tk_to_nxt    = tk_to_r;
    tk_idx_nxt   = tk_idx_r;
    tk_timed_nxt = tk_timed_r;
    pend_v_nxt   = pend_v_r;
    pend_nxt     = pend_r;
    push         = 1'b0;
    push_beat    = pend_r;
    ev_load_we   = 1'b0;
    tm_load_we   = 1'b0;
    ev_rd_en     = 1'b0;
    ev_rd_idx    = ev_rd_r[EvIdxW-1:0];
    tm_addr      = ti_r[TmIdxW-1:0];
    tm_st        = '0;
    emit         = 1'b0;
    emit_beat    = '0;

    if (cfg_valid && cfg_ready && !started_r) begin
      cur_nxt = cfg_data;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_data.op)
            fsme_pkg::OpLoadEvt: ev_load_we = 1'b1;
            fsme_pkg::OpLoadTmd: tm_load_we = 1'b1;
            fsme_pkg::OpTrigger: begin
              ev_nxt  = in_data.event_code;
              now_nxt = in_data.now_ms;
              if (started_r) begin
                ev_rd_nxt = '0;
                chk_v_nxt = 1'b0;
                state_nxt = S_EV_SCAN;
              end
            end
            fsme_pkg::OpRun: begin
              now_nxt   = in_data.now_ms;
              ti_nxt    = '0;
              state_nxt = started_r ? S_RUN_IN : S_RUN_ENTER;
            end
          endcase
        end
      end
      S_RUN_ENTER: begin
        if (emit_ok) begin
          emit        = 1'b1;
          emit_beat   = '{action: fsme_pkg::ActEnter, state_id: cur_r,
                          transition_index: 4'd0, from_timed_table: 1'b0, last: 1'b0};
          started_nxt = 1'b1;
          state_nxt   = S_RUN_IN;
        end
      end
      S_RUN_IN: begin
        if (emit_ok) begin
          emit      = 1'b1;
          emit_beat = '{action: fsme_pkg::ActInState, state_id: cur_r,
                        transition_index: 4'd0, from_timed_table: 1'b0, last: 1'b0};
          state_nxt = S_TM_SCAN;
        end
      end
      S_EV_SCAN: begin
        // read of entry n overlaps the match check of entry n-1
        if (ev_hit) begin
          tk_from_nxt  = ev_rd_ent.from_st;
          tk_to_nxt    = ev_rd_ent.to_st;
          tk_idx_nxt   = 4'(chk_idx_r);
          tk_timed_nxt = 1'b0;
          state_nxt    = S_EXIT;
        end else if (ev_rd_r < ev_count) begin
          ev_rd_en    = 1'b1;
          chk_idx_nxt = ev_rd_r[EvIdxW-1:0];
          chk_v_nxt   = 1'b1;
          ev_rd_nxt   = ev_rd_r + EvCntW'(1);
        end else begin
          state_nxt = S_FLUSH;
        end
      end
      S_TM_SCAN: begin
        if (ti_r < tm_count) begin
          if (tm_rd.from_st != cur_r) begin
            ti_nxt = ti_r + TmCntW'(1);
          end else if (!tm_rd.armed) begin
            tm_st  = '{we: 1'b1, val: now_r};
            ti_nxt = ti_r + TmCntW'(1);
          end else if (tm_rd.fire) begin
            tk_from_nxt  = tm_rd.from_st;
            tk_to_nxt    = tm_rd.to_st;
            tk_idx_nxt   = 4'(ti_r);
            tk_timed_nxt = 1'b1;
            state_nxt    = S_EXIT;
          end else begin
            ti_nxt = ti_r + TmCntW'(1);
          end
        end else begin
          state_nxt = S_FLUSH;
        end
      end
      S_EXIT: begin
        if (emit_ok) begin
          emit      = 1'b1;
          emit_beat = '{action: fsme_pkg::ActExit, state_id: tk_from_r,
                        transition_index: 4'd0, from_timed_table: 1'b0, last: 1'b0};
          state_nxt = S_TRANS;
        end
      end
      S_TRANS: begin
        if (emit_ok) begin
          emit      = 1'b1;
          emit_beat = '{action: fsme_pkg::ActTrans, state_id: '0,
                        transition_index: tk_idx_r, from_timed_table: tk_timed_r,
                        last: 1'b0};
          state_nxt = S_ENTER;
        end
      end
      S_ENTER: begin
        if (emit_ok) begin
          emit      = 1'b1;
          emit_beat = '{action: fsme_pkg::ActEnter, state_id: tk_to_r,
                        transition_index: 4'd0, from_timed_table: 1'b0, last: 1'b0};
          cur_nxt   = tk_to_r;
          rj_nxt    = '0;
          state_nxt = S_REARM;
        end
      end
      S_REARM: begin
        if (rj_r < tm_count) begin
          tm_addr = rj_r[TmIdxW-1:0];
          if (tm_rd.from_st == cur_r) begin
            tm_st = '{we: 1'b1, val: now_r};
          end
          rj_nxt = rj_r + TmCntW'(1);
        end else if (tk_timed_r) begin
          // disarm the entry that fired, then resume the scan after it
          tm_st     = '{we: 1'b1, val: 32'd0};
          ti_nxt    = ti_r + TmCntW'(1);
          state_nxt = S_TM_SCAN;
        end else begin
          state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (!pend_v_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          push           = 1'b1;
          push_beat      = pend_r;
          push_beat.last = 1'b1;
          pend_v_nxt     = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // hold one beat back so the final one can be marked last
    if (emit) begin
      if (pend_v_r) begin
        push      = 1'b1;
        push_beat = pend_r;
      end
      pend_v_nxt = 1'b1;
      pend_nxt   = emit_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cur_r     <= '0;
      started_r <= 1'b0;
      pend_v_r  <= 1'b0;
      chk_v_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cur_r     <= cur_nxt;
      started_r <= started_nxt;
      pend_v_r  <= pend_v_nxt;
      chk_v_r   <= chk_v_nxt;
    end
    ev_r       <= ev_nxt;
    now_r      <= now_nxt;
    ev_rd_r    <= ev_rd_nxt;
    chk_idx_r  <= chk_idx_nxt;
    ti_r       <= ti_nxt;
    rj_r       <= rj_nxt;
    tk_from_r  <= tk_from_nxt;
    tk_to_r    <= tk_to_nxt;
    tk_idx_r   <= tk_idx_nxt;
    tk_timed_r <= tk_timed_nxt;
    pend_r     <= pend_nxt;
  end

`ifndef SYNTHESIS
  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !pend_v_r)
    else $error("held beat left over in idle");

  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> out_free)
    else $error("result beat pushed into a full output register");

  a_started_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !$fell(started_r))
    else $error("started flag cleared outside reset");

  a_start_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    tm_st.we |-> (state_r == S_TM_SCAN || state_r == S_REARM))
    else $error("timer start written outside scan or re-arm");
`endif

endmodule

@@ hw/rtl/event_and_timed_state_machine_engine.sv @@
// Table-driven state machine engine: event and timed transition tables, one sequencer.
// A load, or a trigger before the first run, is taken while the sequencer stays idle. Otherwise
// input stalls while a trigger scans the event entries or a run scans the timed entries, and
// while each transition re-arms the timers of the new state; output stalls add.
// Beats leave one action behind the sequencer, the last on the edge back to idle.
// Synchronous active-low reset empties both tables, clears started and selects state 0.
module event_and_timed_state_machine_engine #(
  parameter int NUM_EVENT_TRANS = 16,
  parameter int NUM_TIMED       = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  fsme_pkg::in_beat_t          in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output fsme_pkg::res_beat_t         out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [fsme_pkg::StateW-1:0] cfg_data
);

  localparam int EvIdxW = (NUM_EVENT_TRANS > 1) ? $clog2(NUM_EVENT_TRANS) : 1;
  localparam int EvCntW = $clog2(NUM_EVENT_TRANS + 1);
  localparam int TmIdxW = (NUM_TIMED > 1) ? $clog2(NUM_TIMED) : 1;
  localparam int TmCntW = $clog2(NUM_TIMED + 1);

  logic                out_valid_r;
  fsme_pkg::res_beat_t out_data_r;
  logic                out_free;
  logic                push;
  fsme_pkg::res_beat_t push_beat;
  logic                ev_load_we, ev_rd_en;
  fsme_pkg::ev_ent_t   ev_load_ent, ev_rd_ent;
  logic [EvIdxW-1:0]   ev_rd_idx;
  logic [EvCntW-1:0]   ev_count;
  logic                tm_load_we;
  fsme_pkg::tm_ent_t   tm_load_ent;
  logic [TmIdxW-1:0]   tm_addr;
  fsme_pkg::tm_stw_t   tm_st;
  logic [31:0]         tm_now;
  fsme_pkg::tm_rd_t    tm_rd;
  logic [TmCntW-1:0]   tm_count;

  fsme_evt_tbl #(.Depth(NUM_EVENT_TRANS)) u_evt_tbl (
    .clk      (clk),
    .rst_n    (rst_n),
    .load_we  (ev_load_we),
    .load_ent (ev_load_ent),
    .rd_en    (ev_rd_en),
    .rd_idx   (ev_rd_idx),
    .rd_ent   (ev_rd_ent),
    .count    (ev_count)
  );

  fsme_tmr_tbl #(.Depth(NUM_TIMED)) u_tmr_tbl (
    .clk      (clk),
    .rst_n    (rst_n),
    .load_we  (tm_load_we),
    .load_ent (tm_load_ent),
    .addr     (tm_addr),
    .st       (tm_st),
    .now      (tm_now),
    .rd       (tm_rd),
    .count    (tm_count)
  );

  fsme_seq #(.EvDepth(NUM_EVENT_TRANS), .TmDepth(NUM_TIMED)) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .out_free    (out_free),
    .push        (push),
    .push_beat   (push_beat),
    .ev_load_we  (ev_load_we),
    .ev_load_ent (ev_load_ent),
    .ev_rd_en    (ev_rd_en),
    .ev_rd_idx   (ev_rd_idx),
    .ev_rd_ent   (ev_rd_ent),
    .ev_count    (ev_count),
    .tm_load_we  (tm_load_we),
    .tm_load_ent (tm_load_ent),
    .tm_addr     (tm_addr),
    .tm_st       (tm_st),
    .tm_now      (tm_now),
    .tm_rd       (tm_rd),
    .tm_count    (tm_count)
  );

  // output register frees when the beat is taken
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_data_r <= push_beat;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ bench/fsme_action_checker.sv @@
// Scoreboard for the state machine engine: predicts action beats and checks the result channel.
module fsme_action_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  fsme_pkg::in_beat_t          in_data,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  fsme_pkg::res_beat_t         out_data,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [fsme_pkg::StateW-1:0] cfg_data,
  output int                          fail_count,
  output int                          pending
);

  localparam int EvDepth = 16;
  localparam int TmDepth = 8;

  logic [fsme_pkg::StateW-1:0] cur_state;
  logic                        running;
  fsme_pkg::ev_ent_t           ev_tab [EvDepth];
  fsme_pkg::tm_ent_t           tm_tab [TmDepth];
  logic [31:0]                 tm_armed_at [TmDepth];
  int                          ev_fill;
  int                          tm_fill;
  fsme_pkg::res_beat_t         step_actions [$];
  fsme_pkg::res_beat_t         expected_actions [$];
  int                          errors = 0;

  function automatic void queue_action(input logic [1:0] act,
                                       input logic [fsme_pkg::StateW-1:0] st,
                                       input logic [3:0] idx, input logic timed);
    fsme_pkg::res_beat_t a;
    a.action           = act;
    a.state_id         = st;
    a.transition_index = idx;
    a.from_timed_table = timed;
    a.last             = 1'b0;
    step_actions.push_back(a);
  endfunction

  // Exit, transition, enter; then re-arm every timer that leaves the new state.
  function automatic void take_transition(input logic [fsme_pkg::StateW-1:0] from_st,
                                          input logic [fsme_pkg::StateW-1:0] to_st,
                                          input logic [3:0] idx, input logic timed,
                                          input logic [31:0] now);
    int k;
    queue_action(fsme_pkg::ActExit, from_st, 4'd0, 1'b0);
    queue_action(fsme_pkg::ActTrans, '0, idx, timed);
    queue_action(fsme_pkg::ActEnter, to_st, 4'd0, 1'b0);
    cur_state = to_st;
    for (k = 0; k < tm_fill; k++) begin
      if (tm_tab[k].from_st == cur_state) tm_armed_at[k] = now;
    end
  endfunction

  function automatic void predict_actions(input fsme_pkg::in_beat_t b);
    int                  k;
    logic                hit;
    logic [31:0]         elapsed;
    fsme_pkg::res_beat_t tail;
    hit = 1'b0;
    case (b.op)
      fsme_pkg::OpLoadEvt: begin
        // drop loads once the table is full
        if (ev_fill < EvDepth) begin
          ev_tab[ev_fill] = '{from_st: b.src_state, key: b.event_code, to_st: b.dst_state};
          ev_fill++;
        end
      end
      fsme_pkg::OpLoadTmd: begin
        if (tm_fill < TmDepth) begin
          tm_tab[tm_fill] = '{from_st: b.src_state, to_st: b.dst_state,
                              interval: b.interval_ms};
          tm_armed_at[tm_fill] = '0;
          tm_fill++;
        end
      end
      fsme_pkg::OpTrigger: begin
        // events before the first run step are dropped; first matching entry wins
        if (running) begin
          for (k = 0; k < ev_fill && !hit; k++) begin
            if (ev_tab[k].from_st == cur_state && ev_tab[k].key == b.event_code) begin
              hit = 1'b1;
              take_transition(ev_tab[k].from_st, ev_tab[k].to_st, 4'(k), 1'b0, b.now_ms);
            end
          end
        end
      end
      fsme_pkg::OpRun: begin
        if (!running) begin
          running = 1'b1;
          queue_action(fsme_pkg::ActEnter, cur_state, 4'd0, 1'b0);
        end
        queue_action(fsme_pkg::ActInState, cur_state, 4'd0, 1'b0);
        for (k = 0; k < tm_fill; k++) begin
          if (tm_tab[k].from_st == cur_state) begin
            elapsed = b.now_ms - tm_armed_at[k];
            if (tm_armed_at[k] == '0) begin
              tm_armed_at[k] = b.now_ms;
            end else if (elapsed >= tm_tab[k].interval) begin
              take_transition(tm_tab[k].from_st, tm_tab[k].to_st, 4'(k), 1'b1, b.now_ms);
              // disarm after the re-arm for the new state
              tm_armed_at[k] = '0;
            end
          end
        end
      end
    endcase
    if (step_actions.size() != 0) begin
      tail = step_actions.pop_back();
      tail.last = 1'b1;
      step_actions.push_back(tail);
      while (step_actions.size() != 0) expected_actions.push_back(step_actions.pop_front());
    end
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      errors++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    fsme_pkg::res_beat_t want;
    if (!rst_n) begin
      cur_state   = '0;
      running     = 1'b0;
      ev_fill     = 0;
      tm_fill     = 0;
      expected_actions.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (!running) cur_state = cfg_data;
      end
      if (in_valid && !in_stall) predict_actions(in_data);
      if (out_valid && !out_stall) begin
        if (expected_actions.size() == 0) begin
          errors++;
          $error("result beat with nothing expected: action %0d state %0d index %0d",
                 out_data.action, out_data.state_id, out_data.transition_index);
        end else begin
          want = expected_actions.pop_front();
          check_field("action", 32'(want.action), 32'(out_data.action));
          check_field("state_id", 32'(want.state_id), 32'(out_data.state_id));
          check_field("transition_index", 32'(want.transition_index),
                      32'(out_data.transition_index));
          check_field("from_timed_table", 32'(want.from_timed_table),
                      32'(out_data.from_timed_table));
          check_field("last", 32'(want.last), 32'(out_data.last));
        end
      end
    end
    pending    = expected_actions.size();
    fail_count = errors;
  end

endmodule

@@ bench/event_and_timed_state_machine_engine_tb.sv @@
// Testbench top for the state machine engine: reset, stimulus, stalls and the verdict.
module event_and_timed_state_machine_engine_tb;

  localparam int EvDepth      = 16;
  localparam int TmDepth      = 8;
  localparam int CycleLimit   = 1_000_000;
  localparam int SettleCycles = 160;

  logic                        clk       = 1'b0;
  logic                        rst_n     = 1'b0;
  logic                        in_valid  = 1'b0;
  fsme_pkg::in_beat_t          in_data   = '0;
  logic                        out_stall = 1'b0;
  logic                        cfg_valid = 1'b0;
  logic [fsme_pkg::StateW-1:0] cfg_data  = '0;
  logic                        in_stall;
  logic                        out_valid;
  fsme_pkg::res_beat_t         out_data;
  logic                        cfg_ready;
  int                          fail_count;
  int                          pending;

  logic              calm      = 1'b0;
  int                stall_left = 0;
  int                ev_loads  = 0;
  int                tm_loads  = 0;
  logic [31:0]       clock_ms  = 32'd1000;
  int unsigned       cycle_cnt = 0;
  logic [7:0]        key_pool   [4] = '{8'h00, 8'hFF, 8'h3C, 8'hC3};
  logic [3:0]        state_pool [6] = '{4'd0, 4'd1, 4'd2, 4'd3, 4'd14, 4'd15};

  event_and_timed_state_machine_engine i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  fsme_action_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Receiver stalls in random bursts unless calm is set.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 10);
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic logic [3:0] pick_state();
    if ($urandom_range(0, 9) < 8) return state_pool[$urandom_range(0, 5)];
    return 4'($urandom);
  endfunction

  function automatic logic [7:0] pick_key();
    if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, 3)];
    return 8'($urandom);
  endfunction

  // Hold the beat until it is taken; leave valid high for a back-to-back follow-up.
  task automatic send_beat(input fsme_pkg::in_beat_t b);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_op(input logic [1:0] op, input logic [3:0] from_st,
                         input logic [3:0] to_st, input logic [7:0] key,
                         input logic [31:0] ival, input logic [31:0] now);
    fsme_pkg::in_beat_t b;
    b.op          = op;
    b.src_state   = from_st;
    b.dst_state   = to_st;
    b.event_code  = key;
    b.interval_ms = ival;
    b.now_ms      = now;
    send_beat(b);
  endtask

  task automatic write_start_state(input logic [fsme_pkg::StateW-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Stop sending and wait until the action queue stays empty for a while.
  task automatic drain_actions();
    int quiet;
    quiet = 0;
    in_valid <= 1'b0;
    while (quiet < SettleCycles) begin
      @(negedge clk);
      if (pending != 0) quiet = 0;
      else quiet++;
    end
    @(posedge clk);
  endtask

  task automatic random_chunk(input int target);
    fsme_pkg::in_beat_t b;
    int                 done;
    int                 r;
    logic               filling;
    done = 0;
    while (done < target) begin
      b.op          = fsme_pkg::OpRun;
      b.src_state   = 4'($urandom);
      b.dst_state   = 4'($urandom);
      b.event_code  = 8'($urandom);
      b.interval_ms = $urandom;
      b.now_ms      = $urandom;
      filling = (ev_loads < EvDepth) || (tm_loads < TmDepth);
      r = $urandom_range(0, 99);
      if (r < (filling ? 25 : 5)) b.op = fsme_pkg::OpLoadEvt;
      else if (r < (filling ? 40 : 10)) b.op = fsme_pkg::OpLoadTmd;
      else if (r < 70) b.op = fsme_pkg::OpTrigger;
      case (b.op)
        fsme_pkg::OpLoadEvt: begin
          b.src_state  = pick_state();
          b.dst_state  = pick_state();
          b.event_code = pick_key();
          ev_loads++;
        end
        fsme_pkg::OpLoadTmd: begin
          b.src_state = pick_state();
          b.dst_state = pick_state();
          r = $urandom_range(0, 99);
          if (r < 15) b.interval_ms = '0;
          else if (r < 25) b.interval_ms = $urandom;
          else if (r < 30) b.interval_ms = '1;
          else b.interval_ms = $urandom_range(0, 150);
          tm_loads++;
        end
        default: begin
          // advance time in small steps, with rare jumps and zero stamps
          r = $urandom_range(0, 99);
          if (r < 4) begin
            b.now_ms = '0;
          end else begin
            if (r < 9) clock_ms = $urandom;
            else clock_ms = clock_ms + $urandom_range(0, 60);
            b.now_ms = clock_ms;
          end
          if (b.op == fsme_pkg::OpTrigger) b.event_code = pick_key();
        end
      endcase
      send_beat(b);
      done++;
    end
  endtask

  initial begin : watchdog
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("FAIL event_and_timed_state_machine_engine");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    write_start_state(4'd9);
    send_op(fsme_pkg::OpLoadEvt, 4'd15, 4'd0, 8'hFF, 32'd0, 32'd0);
    send_op(fsme_pkg::OpLoadEvt, 4'd0, 4'd15, 8'h00, 32'd0, 32'd0);
    // same source and event again: the earlier entry must win
    send_op(fsme_pkg::OpLoadEvt, 4'd0, 4'd7, 8'h00, 32'd0, 32'd0);
    send_op(fsme_pkg::OpLoadTmd, 4'd15, 4'd0, 8'h00, 32'hFFFF_FFFF, 32'd0);
    send_op(fsme_pkg::OpLoadTmd, 4'd0, 4'd15, 8'hFF, 32'd0, 32'd0);
    ev_loads = 3;
    tm_loads = 2;
    drain_actions();

    // before the first run the write also moves the current state
    write_start_state(4'd15);
    // a matching event before the first run step is dropped
    send_op(fsme_pkg::OpTrigger, 4'd0, 4'd0, 8'hFF, 32'd0, 32'd5);
    // zero time stamp leaves the timer unarmed
    send_op(fsme_pkg::OpRun, 4'd0, 4'd0, 8'd0, 32'd0, 32'd0);
    send_op(fsme_pkg::OpRun, 4'd0, 4'd0, 8'd0, 32'd0, 32'hFFFF_FFFF);
    // elapsed time wraps to the maximum; the new state's timer fires in the same scan
    send_op(fsme_pkg::OpRun, 4'd0, 4'd0, 8'd0, 32'd0, 32'hFFFF_FFFE);
    send_op(fsme_pkg::OpTrigger, 4'd0, 4'd0, 8'hFF, 32'd0, 32'd100);
    send_op(fsme_pkg::OpTrigger, 4'd0, 4'd0, 8'h00, 32'd0, 32'd7);
    // no matching entry
    send_op(fsme_pkg::OpTrigger, 4'd0, 4'd0, 8'h5A, 32'd0, 32'd8);
    send_op(fsme_pkg::OpRun, 4'd0, 4'd0, 8'd0, 32'd0, 32'd6);
    send_op(fsme_pkg::OpRun, 4'd0, 4'd0, 8'd0, 32'd0, 32'd0);
    drain_actions();

    // after the start the write leaves the current state unchanged
    write_start_state(4'd0);
    random_chunk(70);
    drain_actions();
    write_start_state(4'd15);
    random_chunk(60);
    drain_actions();
    write_start_state(4'($urandom_range(1, 14)));
    calm = 1'b1;
    random_chunk(55);
    drain_actions();

    if (fail_count == 0) begin
      $display("PASS event_and_timed_state_machine_engine");
    end else begin
      $display("FAIL event_and_timed_state_machine_engine");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/fsme_pkg.sv
hw/rtl/fsme_evt_tbl.sv
hw/rtl/fsme_tmr_tbl.sv
hw/rtl/fsme_seq.sv
hw/rtl/event_and_timed_state_machine_engine.sv
bench/fsme_action_checker.sv
bench/event_and_timed_state_machine_engine_tb.sv
